// ===== sv/pdfesc_pkg.sv =====
// Package for the PDF literal string escape decoder.
// Holds character codes, the decode mode type and the structs shared by the core,
// the output queue and the top level. No dependencies.
package pdfesc_pkg;

    // Characters that the decoder looks for
    localparam logic [7:0] CH_BACKSL = 8'h5C;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [4:0] OCTAL_HI  = 5'b00110;    // '0'..'7' share these upper bits

    // Control bytes produced by the letter escapes
    localparam logic [7:0] CTL_CR = 8'h0D;
    localparam logic [7:0] CTL_LF = 8'h0A;
    localparam logic [7:0] CTL_FF = 8'h0C;
    localparam logic [7:0] CTL_BS = 8'h08;
    localparam logic [7:0] CTL_HT = 8'h09;

    localparam logic [1:0] OCT_DIGITS_MAX = 2'd3;

    // Output queue geometry: room for two results per item plus slack
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;
    localparam logic [QCNT_W-1:0] QROOM_LIMIT = 3'd2;   // accept while count <= this

    // Number of results an item produces
    localparam logic [1:0] NRES_NONE = 2'd0;
    localparam logic [1:0] NRES_ONE  = 2'd1;
    localparam logic [1:0] NRES_TWO  = 2'd2;

    typedef enum logic [1:0] {
        MODE_TEXT  = 2'd0,
        MODE_ESC   = 2'd1,
        MODE_OCTAL = 2'd2
    } mode_t;

    // Results of one item, in order: entry 0 first
    typedef struct packed {
        logic [1:0] n;
        logic [7:0] byte0;
        logic       last0;
        logic [7:0] byte1;
        logic       last1;
    } push_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              has_room;
    } qstat_t;

    function automatic logic is_octal(input logic [7:0] c);
        return c[7:3] == OCTAL_HI;
    endfunction

    function automatic logic [7:0] map_escape(input logic [7:0] c);
        logic [7:0] r;
        unique case (c)
            CH_R:    r = CTL_CR;
            CH_N:    r = CTL_LF;
            CH_F:    r = CTL_FF;
            CH_B:    r = CTL_BS;
            CH_T:    r = CTL_HT;
            default: r = c;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/pdfesc_if.sv =====
// Stream interfaces for the escape decoder: raw input bytes and decoded output bytes.
// Valid/ready handshake; no dependencies.
interface pdfesc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, in_byte, in_last, input ready);
    modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface pdfesc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, out_byte, out_last, input ready);
    modport sink   (input valid, out_byte, out_last, output ready);
endinterface

// ===== sv/pdfesc_top.sv =====
// Top level of the PDF literal string escape decoder.
// Depends on pdfesc_pkg, pdfesc_if, pdfesc_core and pdfesc_outq.
//
//  channel     dir  fields               handshake
//  ---------   ---  -------------------  ----------------------------------
//  in_stream   in   in_byte, in_last     valid/ready, item taken on both high
//  out_stream  out  out_byte, out_last   valid/ready, item taken on both high
//
// One raw byte is accepted per cycle while the queue has room. Each byte is decoded
// in the same cycle it is accepted and yields zero, one or two result items, which
// land in a four-entry output queue, leaving one per cycle while out_stream is ready.
// in_stream.ready is high while the queue holds two or fewer items, so a
// stalled consumer backs up into the input after the queue fills.
// Reset (rst_n, async, active low) returns to text mode and empties the queue.
module pdf_literal_escape_decoder_top (
    input  logic          clk,
    input  logic          rst_n,
    pdfesc_in_if.sink     in_stream,
    pdfesc_out_if.source  out_stream
);
    import pdfesc_pkg::*;

    logic   in_fire;
    logic   out_fire;
    push_t  push;
    qstat_t qstat;

    // An item is taken whenever the queue can absorb the worst case of two results
    assign in_stream.ready = qstat.has_room;
    assign in_fire         = in_stream.valid && in_stream.ready;
    assign out_fire        = out_stream.valid && out_stream.ready;

    // Decode: mode, pending octal value and digit count live here
    pdfesc_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (in_fire),
        .in_byte (in_stream.in_byte),
        .in_last (in_stream.in_last),
        .push    (push)
    );

    // Result queue: parts the input handshake from the output handshake
    pdfesc_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (out_fire),
        .out_valid (out_stream.valid),
        .out_byte  (out_stream.out_byte),
        .out_last  (out_stream.out_last),
        .stat      (qstat)
    );

    // An item never produces more than two results
    a_push_max: assert property (@(posedge clk) disable iff (!rst_n)
        push.n != 2'd3)
        else $error("decoder produced more than two results");

    // Queue occupancy stays within its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.count <= QCNT_W'(QDEPTH))
        else $error("output queue overflow");

    // Results pushed by an accepted item are visible next cycle
    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n != NRES_NONE) |=> out_stream.valid)
        else $error("pushed result not presented");

    // Output valid only drops after the last queued item was taken
    a_valid_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_stream.valid) |-> $past(out_fire))
        else $error("output valid dropped without a transfer");

endmodule

// ===== sv/pdfesc_core.sv =====
// Escape decode core: mode / octal registers and the per-byte decode logic.
// Depends on pdfesc_pkg.
module pdfesc_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    output pdfesc_pkg::push_t   push
);
    import pdfesc_pkg::*;

    mode_t      mode_reg, mode_next;
    logic [7:0] oct_val_reg, oct_val_next;
    logic [1:0] oct_cnt_reg, oct_cnt_next;
    push_t      res;
    logic [7:0] oct_acc;
    logic [1:0] oct_inc;

    always_comb
    begin
        res          = '0;
        mode_next    = mode_reg;
        oct_val_next = oct_val_reg;
        oct_cnt_next = oct_cnt_reg;
        oct_acc      = {oct_val_reg[4:0], in_byte[2:0]};
        oct_inc      = oct_cnt_reg + 2'd1;

        unique case (mode_reg)
            MODE_ESC:
            begin
                if (is_octal(in_byte))
                begin
                    if (in_last)
                    begin
                        res.n        = NRES_ONE;
                        res.byte0    = {5'd0, in_byte[2:0]};
                        res.last0    = 1'b1;
                        mode_next    = MODE_TEXT;
                        oct_val_next = '0;
                        oct_cnt_next = '0;
                    end
                    else
                    begin
                        mode_next    = MODE_OCTAL;
                        oct_val_next = {5'd0, in_byte[2:0]};
                        oct_cnt_next = 2'd1;
                    end
                end
                else
                begin
                    // delimiters and unknown bytes map to themselves
                    res.n     = NRES_ONE;
                    res.byte0 = map_escape(in_byte);
                    res.last0 = in_last;
                    mode_next = MODE_TEXT;
                end
            end
            MODE_OCTAL:
            begin
                if (is_octal(in_byte))
                begin
                    if (oct_inc == OCT_DIGITS_MAX || in_last)
                    begin
                        res.n        = NRES_ONE;
                        res.byte0    = oct_acc;
                        res.last0    = in_last;
                        mode_next    = MODE_TEXT;
                        oct_val_next = '0;
                        oct_cnt_next = '0;
                    end
                    else
                    begin
                        oct_val_next = oct_acc;
                        oct_cnt_next = oct_inc;
                    end
                end
                else
                begin
                    // flush pending value, then treat the byte as plain text
                    res.byte0    = oct_val_reg;
                    res.last0    = 1'b0;
                    oct_val_next = '0;
                    oct_cnt_next = '0;
                    if (in_byte == CH_BACKSL && !in_last)
                    begin
                        res.n     = NRES_ONE;
                        mode_next = MODE_ESC;
                    end
                    else
                    begin
                        res.n     = NRES_TWO;
                        res.byte1 = in_byte;
                        res.last1 = in_last;
                        mode_next = MODE_TEXT;
                    end
                end
            end
            default:
            begin
                // text mode; unused code behaves the same
                if (in_byte == CH_BACKSL && !in_last)
                    mode_next = MODE_ESC;
                else
                begin
                    res.n     = NRES_ONE;
                    res.byte0 = in_byte;
                    res.last0 = in_last;
                    mode_next = MODE_TEXT;
                end
            end
        endcase
    end

    always_comb
    begin
        push   = res;
        push.n = fire ? res.n : NRES_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_TEXT;
            oct_val_reg <= '0;
            oct_cnt_reg <= '0;
        end
        else if (fire)
        begin
            mode_reg    <= mode_next;
            oct_val_reg <= oct_val_next;
            oct_cnt_reg <= oct_cnt_next;
        end
    end

endmodule

// ===== sv/pdfesc_outq.sv =====
// Output queue: four registers written up to two at a time, drained one per cycle on pop.
// Depends on pdfesc_pkg.
module pdfesc_outq (
    input  logic               clk,
    input  logic               rst_n,
    input  pdfesc_pkg::push_t  push,
    input  logic               pop,
    output logic               out_valid,
    output logic [7:0]         out_byte,
    output logic               out_last,
    output pdfesc_pkg::qstat_t stat
);
    import pdfesc_pkg::*;

    logic [8:0]        mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic [QPTR_W-1:0] wr_ptr_2nd;

    assign wr_ptr_2nd  = wr_ptr_reg + QPTR_W'(1);
    assign wr_ptr_next = wr_ptr_reg + push.n;
    assign rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
    assign count_next  = count_reg + QCNT_W'(push.n) - QCNT_W'(pop);

    assign out_valid     = count_reg != '0;
    assign {out_byte, out_last} = mem_reg[rd_ptr_reg];
    assign stat.count    = count_reg;
    assign stat.has_room = count_reg <= QROOM_LIMIT;

    always_ff @(posedge clk)
    begin
        if (push.n != NRES_NONE)
            mem_reg[wr_ptr_reg] <= {push.byte0, push.last0};
        if (push.n == NRES_TWO)
            mem_reg[wr_ptr_2nd] <= {push.byte1, push.last1};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sim/tb_pdf_literal_escape_decoder_top.sv =====
// Testbench for pdf_literal_escape_decoder_top: raw literal-string bytes in, unescaped bytes out.
// Depends on pdfesc_pkg, pdfesc_if and the decoder RTL; a small class predicts and checks
// the decoded byte stream while plain tasks drive both valid/ready channels.
module tb_pdf_literal_escape_decoder_top;
    import pdfesc_pkg::*;

    // Watchdog: cycles with no item moving on either channel before giving up.
    // Longest legal quiet stretch is the receiver hold-off below plus a few gaps.
    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AFTER    = 200;   // decoded items seen before the hold-off
    localparam int RANDOM_ITEMS  = 700;
    localparam int DRAIN_CYCLES  = 20;

    localparam logic [7:0] DIGIT_0 = 8'h30;
    localparam logic [7:0] DIGIT_7 = 8'h37;

    // The ten delimiters that a backslash may quote
    localparam logic [7:0] DELIMS [10] = '{8'h28, 8'h29, 8'h3C, 8'h3E, 8'h5B,
                                           8'h5D, 8'h7B, 8'h7D, 8'h2F, 8'h25};
    localparam logic [7:0] LETTERS [5] = '{CH_R, CH_N, CH_F, CH_B, CH_T};

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } decoded_t;

    // ------------------------------------------------------------------
    // Decoded-byte predictor and checker. Tracks the escape state on its
    // own and keeps the decoded bytes still owed by the block, in order.
    // ------------------------------------------------------------------
    class decoded_byte_board;
        mode_t      mode;
        logic [7:0] oct_acc;
        logic [1:0] oct_cnt;
        decoded_t   due[$];
        int         errors;
        int         n_checked;

        function new();
            mode      = MODE_TEXT;
            oct_acc   = '0;
            oct_cnt   = '0;
            errors    = 0;
            n_checked = 0;
        endfunction

        function bit is_oct_digit(logic [7:0] c);
            return c >= DIGIT_0 && c <= DIGIT_7;
        endfunction

        // Letter escapes give control bytes; anything else maps to itself
        function logic [7:0] control_for(logic [7:0] c);
            case (c)
                CH_R:    return CTL_CR;
                CH_N:    return CTL_LF;
                CH_F:    return CTL_FF;
                CH_B:    return CTL_BS;
                CH_T:    return CTL_HT;
                default: return c;
            endcase
        endfunction

        function void owe(logic [7:0] d, logic f);
            decoded_t e;
            e.data = d;
            e.fin  = f;
            due.push_back(e);
        endfunction

        function void end_octal();
            mode    = MODE_TEXT;
            oct_acc = '0;
            oct_cnt = '0;
        endfunction

        // Plain text handling; a backslash that ends the string is kept
        function void text_in(logic [7:0] c, logic f);
            if (c == CH_BACKSL && !f)
                mode = MODE_ESC;
            else
            begin
                owe(c, f);
                mode = MODE_TEXT;
            end
        endfunction

        function void note_raw(logic [7:0] c, logic f);
            case (mode)
                MODE_ESC:
                begin
                    if (is_oct_digit(c))
                    begin
                        oct_acc = {5'b0, c[2:0]};
                        oct_cnt = 2'd1;
                        mode    = MODE_OCTAL;
                        if (f)
                        begin
                            owe(oct_acc, 1'b1);
                            end_octal();
                        end
                    end
                    else
                    begin
                        owe(control_for(c), f);
                        mode = MODE_TEXT;
                    end
                end
                MODE_OCTAL:
                begin
                    if (is_oct_digit(c))
                    begin
                        oct_acc = {oct_acc[4:0], c[2:0]};   // times 8, mod 256
                        oct_cnt = oct_cnt + 2'd1;
                        if (oct_cnt == 2'd3 || f)
                        begin
                            owe(oct_acc, f);
                            end_octal();
                        end
                    end
                    else
                    begin
                        owe(oct_acc, 1'b0);
                        end_octal();
                        text_in(c, f);
                    end
                end
                default:
                    text_in(c, f);
            endcase
        endfunction

        function void check_decoded(logic [7:0] d, logic f);
            decoded_t e;
            if (due.size() == 0)
            begin
                $error("unexpected item: out_byte %h out_last %b", d, f);
                errors++;
                return;
            end
            e = due.pop_front();
            n_checked++;
            if (e.data !== d)
            begin
                $error("out_byte mismatch: expected %h, actual %h", e.data, d);
                errors++;
            end
            if (e.fin !== f)
            begin
                $error("out_last mismatch: expected %b, actual %b", e.fin, f);
                errors++;
            end
        endfunction

        function int pending();
            return due.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    pdfesc_in_if  in_ch ();
    pdfesc_out_if out_ch ();

    pdf_literal_escape_decoder_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_ch),
        .out_stream (out_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    decoded_byte_board sb = new();

    int n_raw     = 0;
    int n_strings = 0;
    int in_calm   = 0;
    int out_calm  = 0;
    bit held_off  = 1'b0;

    // Per-item random wait, with occasional runs of back-to-back items
    function automatic int draw_gap(ref int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
            calm = $urandom_range(20, 60);
        return $urandom_range(0, 10);
    endfunction

    // Offer one raw byte and wait for the block to take it.
    // Returns at the accepting edge, so the caller's next assignment to
    // valid lands in the same step without a second one before it.
    task automatic send_raw(logic [7:0] c, logic f);
        int gap;
        gap = draw_gap(in_calm);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= c;
        in_ch.in_last <= f;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_raw(c, f);
        n_raw++;
    endtask

    // One literal string; in_last rides on its final byte
    task automatic send_string(logic [7:0] s[$]);
        for (int i = 0; i < s.size(); i++)
            send_raw(s[i], i == s.size() - 1);
        n_strings++;
    endtask

    // Random string: mostly well-formed escapes with random content, some noise.
    // Short octal runs followed by any other piece exercise the cut-short path.
    task automatic random_string();
        logic [7:0] s[$];
        logic [7:0] c;
        int         kind;
        int         ndig;
        if ($urandom_range(0, 9) == 0)
        begin
            // pure noise, backslashes and all
            repeat ($urandom_range(1, 6)) s.push_back(8'($urandom));
        end
        else
        begin
            repeat ($urandom_range(1, 8))
            begin
                kind = $urandom_range(0, 9);
                case (kind)
                    0, 1, 2:
                    begin
                        c = 8'($urandom);
                        if (c == CH_BACKSL)
                            c = 8'h41;
                        s.push_back(c);
                    end
                    3:
                    begin
                        s.push_back(CH_BACKSL);
                        s.push_back(DELIMS[$urandom_range(0, 9)]);
                    end
                    4:
                    begin
                        s.push_back(CH_BACKSL);
                        s.push_back(LETTERS[$urandom_range(0, 4)]);
                    end
                    5, 6:
                    begin
                        s.push_back(CH_BACKSL);
                        ndig = $urandom_range(1, 3);
                        repeat (ndig) s.push_back(8'(DIGIT_0 + $urandom_range(0, 7)));
                    end
                    7:
                    begin
                        // backslash before any byte, a second backslash included
                        s.push_back(CH_BACKSL);
                        s.push_back(8'($urandom));
                    end
                    8:
                        s.push_back(8'($urandom));
                    default:
                    begin
                        // full three-digit escape, then a digit that is plain text
                        s.push_back(CH_BACKSL);
                        repeat (4) s.push_back(8'(DIGIT_0 + $urandom_range(0, 7)));
                    end
                endcase
            end
            if ($urandom_range(0, 7) == 0)
                s.push_back(CH_BACKSL);      // trailing backslash
        end
        send_string(s);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off so the output queue
    // fills and the block pushes back on its input.
    // ------------------------------------------------------------------
    initial
    begin : result_side
        int gap;
        out_ch.ready <= 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (!held_off && sb.n_checked >= HOLD_AFTER)
            begin
                held_off = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = draw_gap(out_calm);
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            sb.check_decoded(out_ch.out_byte, out_ch.out_last);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: a long run with nothing moving means the block hung or
    // still owes results it will never send.
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: %0d items still owed", sb.pending());
        $display("pdf_literal_escape_decoder_top test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        logic [7:0] s[$];
        int         random_start;

        in_ch.valid   <= 1'b0;
        in_ch.in_byte <= 8'h00;
        in_ch.in_last <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero byte, \r, then \0 cut short by a final 'A': byte 0 then 'A'
        s = '{8'h00, CH_BACKSL, CH_R, CH_BACKSL, 8'h30, 8'h41};
        send_string(s);
        // \777 wraps to 255 on the third digit; the fourth digit is plain; 0xFF ends
        s = '{CH_BACKSL, 8'h37, 8'h37, 8'h37, 8'h34, 8'hFF};
        send_string(s);
        // quoted delimiter, double backslash, two-digit octal flushed at the end
        s = '{CH_BACKSL, 8'h28, CH_BACKSL, CH_BACKSL, CH_BACKSL, 8'h31, 8'h32};
        send_string(s);
        // octal cut short by a backslash that opens \t
        s = '{CH_BACKSL, 8'h37, CH_BACKSL, CH_T};
        send_string(s);
        // lone trailing backslash
        s = '{CH_BACKSL};
        send_string(s);
        // single octal digit as the last byte
        s = '{CH_BACKSL, 8'h35};
        send_string(s);
        // octal cut short by a trailing backslash: two items from one byte
        s = '{CH_BACKSL, 8'h36, CH_BACKSL};
        send_string(s);

        random_start = n_raw;
        while (n_raw - random_start < RANDOM_ITEMS)
            random_string();
        in_ch.valid <= 1'b0;

        // Wait for everything owed, then a short drain to catch stray items
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d strings, %0d raw bytes, %0d decoded bytes checked,",
                 n_strings, n_raw, sb.n_checked);
        $display("with random stalls on both sides and a %0d-cycle output hold-off.",
                 HOLD_CYCLES);
        if (sb.errors == 0)
            $display("pdf_literal_escape_decoder_top test passed");
        else
            $display("pdf_literal_escape_decoder_top test failed");
        $finish;
    end

endmodule
